### sv/smt_pkg.sv
// Shared constants, codes and inter-module structs of the set membership table.
package smt_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned STAT_W   = 2;
  localparam int unsigned MCNT_W   = 7;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ADD    = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_SEARCH = 2'd2
  } func_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_HOLD
  } state_e;

  // Lookup token that walks the cell chain.
  typedef struct packed {
    logic                    vld;
    logic signed [VAL_W-1:0] value;
    logic                    hit;
    logic [IDX_W-1:0]        hit_idx;
    logic                    free;
    logic [IDX_W-1:0]        free_idx;
  } tok_t;

  // Update broadcast to all cells once the walk is done.
  typedef struct packed {
    logic                    wr;
    logic                    clr;
    logic [IDX_W-1:0]        idx;
    logic signed [VAL_W-1:0] value;
  } cmt_t;

endpackage

### sv/smt_req_if.sv
// Request channel: operation code and element value.
interface smt_req_if;
  logic                            valid;
  logic                            ready;
  logic [smt_pkg::FUNC_W-1:0]      func;
  logic signed [smt_pkg::VAL_W-1:0] value;

  modport source (output valid, func, value, input ready);
  modport sink   (input valid, func, value, output ready);
endinterface

### sv/smt_rsp_if.sv
// Response channel: status, member count and empty flag.
interface smt_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [smt_pkg::STAT_W-1:0] status;
  logic [smt_pkg::MCNT_W-1:0] member_count;
  logic                       is_empty;

  modport source (output valid, status, member_count, is_empty, input ready);
  modport sink   (input valid, status, member_count, is_empty, output ready);
endinterface

### sv/set_membership_table.sv
// Top level of the set membership table: sequencer plus a chain of entry cells.
//
// A set of up to CAPACITY distinct signed 32-bit values. Each request adds,
// removes or searches one value and gets exactly one response carrying a
// status (done/found, duplicate/absent, full), the member count after the
// operation and an empty flag. A request is taken only while the block is
// idle. Its lookup token then walks the cell chain, one cell per cycle,
// picking up the first matching slot and the lowest free slot; when it
// leaves the last cell the outcome is decided and the chosen slot is written
// or cleared. The outcome is registered in the sequencer, then loaded into
// the output register once that register is free or its response is taken,
// and only then does the block return to idle; a new request cannot be
// accepted before the previous one has walked the whole chain.
// The response sits in an output register, so the next request can be taken
// while a response still waits for the sink. Add of a present value reports
// a duplicate even when the table is full. Entries start invalid after reset;
// no clearing pass is needed.
module set_membership_table (
  input  logic       clk_i,
  input  logic       rst_ni,
  smt_req_if.sink    req_i,
  smt_rsp_if.source  rsp_o
);
  import smt_pkg::*;

  // tok[i] enters cell i; tok[CAPACITY] comes back to the sequencer
  tok_t tok [CAPACITY+1];
  cmt_t cmt;

  smt_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (req_i.valid),
    .in_ready_o   (req_i.ready),
    .in_func_i    (req_i.func),
    .in_value_i   (req_i.value),
    .tok_o        (tok[0]),
    .tok_i        (tok[CAPACITY]),
    .cmt_o        (cmt),
    .out_valid_o  (rsp_o.valid),
    .out_ready_i  (rsp_o.ready),
    .out_status_o (rsp_o.status),
    .out_count_o  (rsp_o.member_count),
    .out_empty_o  (rsp_o.is_empty)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    smt_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (IDX_W'(i)),
      .tok_i      (tok[i]),
      .tok_o      (tok[i+1]),
      .cmt_i      (cmt)
    );
  end

endmodule

### sv/smt_cell.sv
// One table slot: holds an entry and passes the lookup token to its neighbor.
module smt_cell (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [smt_pkg::IDX_W-1:0] cell_idx_i,
  input  smt_pkg::tok_t            tok_i,
  output smt_pkg::tok_t            tok_o,
  input  smt_pkg::cmt_t            cmt_i
);
  import smt_pkg::*;

  logic signed [VAL_W-1:0] value_q;
  logic                    valid_q;
  tok_t                    tok_d, tok_q;
  logic                    match;
  logic                    sel;

  assign match = valid_q && (value_q == tok_i.value);
  assign sel   = (cmt_i.idx == cell_idx_i);

  always_comb begin
    tok_d = tok_i;
    if (!tok_i.hit && match) begin
      tok_d.hit     = 1'b1;
      tok_d.hit_idx = cell_idx_i;
    end
    if (!tok_i.free && !valid_q) begin
      tok_d.free     = 1'b1;
      tok_d.free_idx = cell_idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (sel && cmt_i.wr) begin
      valid_q <= 1'b1;
    end else if (sel && cmt_i.clr) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sel && cmt_i.wr) begin
      value_q <= cmt_i.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

### sv/smt_ctrl.sv
// Sequencer: launches the token, decides the operation outcome, holds the result.
module smt_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [smt_pkg::FUNC_W-1:0]    in_func_i,
  input  logic signed [smt_pkg::VAL_W-1:0] in_value_i,
  output smt_pkg::tok_t                 tok_o,
  input  smt_pkg::tok_t                 tok_i,
  output smt_pkg::cmt_t                 cmt_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [smt_pkg::STAT_W-1:0]    out_status_o,
  output logic [smt_pkg::MCNT_W-1:0]    out_count_o,
  output logic                          out_empty_o
);
  import smt_pkg::*;

  state_e            state_q, state_d;
  logic [FUNC_W-1:0] func_q;
  logic [CNT_W-1:0]  count_q, count_d;
  status_e           res_q, res_d;
  logic              out_valid_q, out_valid_d;
  logic [STAT_W-1:0] out_status_q;
  logic [MCNT_W-1:0] out_count_q;
  logic              out_empty_q;
  logic              accept;
  logic              load;

  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    tok_o          = '0;
    tok_o.vld      = accept;
    tok_o.value    = in_value_i;
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    res_d       = res_q;
    in_ready_o  = 1'b0;
    load        = 1'b0;
    cmt_o       = '0;
    cmt_o.value = tok_i.value;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = S_WALK;
        end
      end
      S_WALK: begin
        if (tok_i.vld) begin
          state_d = S_HOLD;
          unique case (func_q)
            FUNC_ADD: begin
              if (tok_i.hit) begin
                res_d = ST_MISS;
              end else if (!tok_i.free) begin
                res_d = ST_FULL;
              end else begin
                res_d     = ST_OK;
                cmt_o.wr  = 1'b1;
                cmt_o.idx = tok_i.free_idx;
                count_d   = count_q + CNT_W'(1);
              end
            end
            FUNC_REMOVE: begin
              if (tok_i.hit) begin
                res_d     = ST_OK;
                cmt_o.clr = 1'b1;
                cmt_o.idx = tok_i.hit_idx;
                if (count_q != '0) begin
                  count_d = count_q - CNT_W'(1);
                end
              end else begin
                res_d = ST_MISS;
              end
            end
            default: begin
              // search, and the unused code behaves the same
              res_d = tok_i.hit ? ST_OK : ST_MISS;
            end
          endcase
        end
      end
      S_HOLD: begin
        if (!out_valid_q || out_ready_i) begin
          load    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (accept) begin
      func_q <= in_func_i;
    end
    if (load) begin
      out_status_q <= res_q;
      out_count_q  <= MCNT_W'(count_q);
      out_empty_q  <= (count_q == '0);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_count_o  = out_count_q;
  assign out_empty_o  = out_empty_q;

endmodule

### sv/smt_checker.sv
// Port-level checks of the set membership table and their bind.
module smt_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [smt_pkg::STAT_W-1:0] out_status_i,
  input logic [smt_pkg::MCNT_W-1:0] out_count_i,
  input logic                       out_empty_i
);
  import smt_pkg::*;

  // one transaction in flight: ready drops right after an accept
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("request accepted while previous one in flight");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_empty_i) |-> (out_count_i == '0))
    else $error("empty flag with nonzero member count");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && (out_status_i == ST_FULL)) |-> (out_count_i == MCNT_W'(CAPACITY)))
    else $error("full status below capacity");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(out_status_i) && $stable(out_count_i) && $stable(out_empty_i)))
    else $error("stalled response changed");

endmodule

bind set_membership_table smt_checker u_smt_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (req_i.valid),
  .in_ready_i   (req_i.ready),
  .out_valid_i  (rsp_o.valid),
  .out_ready_i  (rsp_o.ready),
  .out_status_i (rsp_o.status),
  .out_count_i  (rsp_o.member_count),
  .out_empty_i  (rsp_o.is_empty)
);

### dv/set_membership_table_tb.sv
// Testbench of the set membership table: random add/remove/search traffic with a scoreboard.
module set_membership_table_tb;
  import smt_pkg::*;

  // The spare selector value; the block treats it as a search.
  localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;
  localparam int unsigned RANDOM_OPS   = 900;
  localparam int unsigned POOL_SIZE    = 8;
  // One transaction walks the whole chain, so this covers any leftover work.
  localparam int unsigned DRAIN_CYCLES = CAPACITY + 10;
  localparam int unsigned LIMIT_CYCLES = 1_000_000;
  localparam int unsigned PRINT_CAP    = 100;

  typedef struct packed {
    logic [FUNC_W-1:0]       func;
    logic signed [VAL_W-1:0] value;
  } set_op_t;

  typedef struct packed {
    status_e           status;
    logic [MCNT_W-1:0] member_count;
    logic              is_empty;
  } set_answer_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  smt_req_if req_bus ();
  smt_rsp_if rsp_bus ();

  set_membership_table i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  always #1 clk_i = ~clk_i;

  set_op_t     op_queue[$];      // operations not yet offered to the block
  set_answer_t answer_queue[$];  // answers owed by the block, oldest first

  // Shadow copy of the table contents
  logic [VAL_W-1:0] shadow_value[CAPACITY];
  bit               shadow_used[CAPACITY];
  int unsigned      shadow_count;

  int unsigned mismatch_count;
  int unsigned cycle_count;
  logic        req_taken;

  logic [VAL_W-1:0] member_pool[POOL_SIZE];

  task automatic report_mismatch(input string msg);
    if (mismatch_count < PRINT_CAP) begin
      $display("ERROR @%0t: %s", $time, msg);
    end
    mismatch_count++;
  endtask

  // Apply one operation to the shadow table and return the answer it owes.
  function automatic set_answer_t predict_answer(set_op_t op);
    int          hit_idx;
    int          free_idx;
    set_answer_t ans;
    hit_idx  = -1;
    free_idx = -1;
    for (int i = 0; i < CAPACITY; i++) begin
      if (shadow_used[i] && shadow_value[i] == op.value && hit_idx < 0) hit_idx = i;
      if (!shadow_used[i] && free_idx < 0) free_idx = i;
    end
    case (op.func)
      FUNC_ADD: begin
        // duplicate wins over full
        if (hit_idx >= 0) begin
          ans.status = ST_MISS;
        end else if (free_idx < 0) begin
          ans.status = ST_FULL;
        end else begin
          shadow_value[free_idx] = op.value;
          shadow_used[free_idx]  = 1'b1;
          shadow_count++;
          ans.status = ST_OK;
        end
      end
      FUNC_REMOVE: begin
        if (hit_idx >= 0) begin
          shadow_used[hit_idx] = 1'b0;
          shadow_count--;
          ans.status = ST_OK;
        end else begin
          ans.status = ST_MISS;
        end
      end
      default: begin
        ans.status = (hit_idx >= 0) ? ST_OK : ST_MISS;
      end
    endcase
    ans.member_count = MCNT_W'(shadow_count);
    ans.is_empty     = (shadow_count == 0);
    return ans;
  endfunction

  task automatic push_op(input logic [FUNC_W-1:0] f, input logic [VAL_W-1:0] v);
    set_op_t op;
    op.func  = f;
    op.value = v;
    op_queue.push_back(op);
  endtask

  function automatic logic [FUNC_W-1:0] random_func();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r <= 5) return FUNC_ADD;
    if (r <= 10) return FUNC_REMOVE;
    if (r <= 14) return FUNC_SEARCH;
    return FUNC_SPARE;
  endfunction

  // Mostly full-range values, with corners and small signed numbers mixed in.
  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      1, 2, 3: return VAL_W'($signed($urandom_range(0, 16)) - 8);
      default: return $urandom;
    endcase
  endfunction

  // Fill the table past capacity, poke at it while full, then drain it.
  task automatic fill_and_drain();
    logic [VAL_W-1:0] added[$];
    logic [VAL_W-1:0] v;
    logic [VAL_W-1:0] swap;
    int unsigned      j;
    for (int k = 0; k < CAPACITY + 4; k++) begin
      v = $urandom;
      push_op(FUNC_ADD, v);
      added.push_back(v);
      if ($urandom_range(0, 7) == 0) push_op(FUNC_SEARCH, added[$urandom_range(0, k)]);
    end
    // early entries are surely present: duplicate into a full table
    for (int k = 0; k < 4; k++) begin
      push_op(FUNC_ADD, added[$urandom_range(0, CAPACITY / 2)]);
      push_op(FUNC_ADD, $urandom);
    end
    for (int i = added.size() - 1; i > 0; i--) begin
      j        = $urandom_range(0, i);
      swap     = added[i];
      added[i] = added[j];
      added[j] = swap;
    end
    foreach (added[i]) begin
      push_op(FUNC_REMOVE, added[i]);
      if ($urandom_range(0, 9) == 0) push_op(random_func(), added[i]);
    end
    foreach (member_pool[i]) push_op(FUNC_REMOVE, member_pool[i]);
  endtask

  // Operations over a small pool of values so that hits are common.
  task automatic pool_episode();
    foreach (member_pool[i]) member_pool[i] = pick_value();
    repeat ($urandom_range(20, 40)) begin
      if ($urandom_range(0, 19) < 17) begin
        push_op(random_func(), member_pool[$urandom_range(0, POOL_SIZE - 1)]);
      end else begin
        push_op(random_func(), pick_value());
      end
    end
  endtask

  // Request sender: bursts of random length with random gaps in between.
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;

  always @(negedge clk_i) begin
    set_op_t nxt;
    if (!rst_ni) begin
      req_bus.valid <= 1'b0;
    end else if (!req_bus.valid || req_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        req_bus.valid <= 1'b0;
      end else if (op_queue.size() != 0) begin
        nxt = op_queue.pop_front();
        req_bus.valid <= 1'b1;
        req_bus.func  <= nxt.func;
        req_bus.value <= nxt.value;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 20);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 :
                       ($urandom_range(0, 7) == 0) ? $urandom_range(20, 90) :
                                                     $urandom_range(1, 10);
        end
      end else begin
        req_bus.valid <= 1'b0;
      end
    end
  end

  // Response sink: ready follows a pattern that changes every so often.
  int unsigned stall_mode;
  int unsigned stall_left = 0;
  int unsigned stall_phase = 0;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      rsp_bus.ready <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(20, 200);
      end else begin
        stall_left--;
      end
      stall_phase++;
      case (stall_mode)
        0: rsp_bus.ready <= 1'b1;
        1: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
        2: rsp_bus.ready <= ((stall_phase % 9) < 3);
        default: rsp_bus.ready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  // Monitor: check responses first, then record the newly accepted request.
  always @(posedge clk_i) begin
    set_op_t     op;
    set_answer_t want;
    if (rst_ni) begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        if (answer_queue.size() == 0) begin
          report_mismatch($sformatf("unexpected response: status %0d count %0d empty %0b",
                                    rsp_bus.status, rsp_bus.member_count, rsp_bus.is_empty));
        end else begin
          want = answer_queue.pop_front();
          if (rsp_bus.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d",
                                      rsp_bus.status, want.status));
          if (rsp_bus.member_count !== want.member_count)
            report_mismatch($sformatf("member_count %0d, expected %0d",
                                      rsp_bus.member_count, want.member_count));
          if (rsp_bus.is_empty !== want.is_empty)
            report_mismatch($sformatf("is_empty %0b, expected %0b",
                                      rsp_bus.is_empty, want.is_empty));
        end
      end
      if (req_bus.valid && req_bus.ready) begin
        op.func  = req_bus.func;
        op.value = req_bus.value;
        answer_queue.push_back(predict_answer(op));
      end
    end
    req_taken <= rst_ni && req_bus.valid && req_bus.ready;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int unsigned directed_ops;
    req_bus.valid = 1'b0;
    req_bus.func  = FUNC_SEARCH;
    req_bus.value = '0;
    rsp_bus.ready = 1'b0;
    req_taken     = 1'b0;
    rst_ni        = 1'b0;

    // Directed: empty-table misses, corner values, duplicate, slot reuse, drain.
    push_op(FUNC_SEARCH, 32'h0000_0000);
    push_op(FUNC_REMOVE, 32'h0000_0005);
    push_op(FUNC_SPARE,  32'h0000_0000);
    push_op(FUNC_ADD,    32'h8000_0000);
    push_op(FUNC_ADD,    32'h7FFF_FFFF);
    push_op(FUNC_ADD,    32'h0000_0000);
    push_op(FUNC_ADD,    32'hFFFF_FFFF);
    push_op(FUNC_ADD,    32'h8000_0000);
    push_op(FUNC_SEARCH, 32'h7FFF_FFFF);
    push_op(FUNC_SPARE,  32'hFFFF_FFFF);
    push_op(FUNC_SEARCH, 32'h0000_0001);
    push_op(FUNC_REMOVE, 32'h0000_0000);
    push_op(FUNC_ADD,    32'h5555_5555);
    push_op(FUNC_ADD,    32'hAAAA_AAAA);
    push_op(FUNC_REMOVE, 32'h8000_0000);
    push_op(FUNC_REMOVE, 32'h7FFF_FFFF);
    push_op(FUNC_REMOVE, 32'hFFFF_FFFF);
    push_op(FUNC_REMOVE, 32'h5555_5555);
    push_op(FUNC_REMOVE, 32'hAAAA_AAAA);
    push_op(FUNC_REMOVE, 32'hAAAA_AAAA);
    push_op(FUNC_SEARCH, 32'h8000_0000);
    directed_ops = op_queue.size();

    // Random: start with a full-table pass, then mostly pool traffic.
    foreach (member_pool[i]) member_pool[i] = pick_value();
    fill_and_drain();
    while (op_queue.size() < directed_ops + RANDOM_OPS) begin
      case ($urandom_range(0, 9))
        0: fill_and_drain();
        1: repeat (8) push_op(FUNC_W'($urandom_range(0, 3)), $urandom);
        default: pool_episode();
      endcase
    end

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (op_queue.size() != 0 || req_bus.valid) @(posedge clk_i);
    while (answer_queue.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### files.f
sv/smt_pkg.sv
sv/smt_req_if.sv
sv/smt_rsp_if.sv
sv/smt_cell.sv
sv/smt_ctrl.sv
sv/set_membership_table.sv
sv/smt_checker.sv
dv/set_membership_table_tb.sv
